[hdl/rht_pkg.sv]
// ----------------------------------------------------------------------------
// Reference-counted handle table: shared definitions
// Types, codes and default sizes used by the table's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rht_pkg;

  localparam int ENTRIES_DEF   = 256;
  localparam int REF_WIDTH_DEF = 16;
  localparam int TAG_WIDTH_DEF = 32;

  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 56;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_CREATE   = 3'd1,
    OP_MOVE     = 3'd2,
    OP_DESTROY  = 3'd3,
    OP_CHECKOUT = 3'd4,
    OP_CHECKIN  = 3'd5,
    OP_VALIDATE = 3'd6
  } req_op_t;

  typedef enum logic [2:0] {
    RC_OK             = 3'd0,
    RC_INVALID_HANDLE = 3'd1,
    RC_INVALID_STATE  = 3'd2,
    RC_ALREADY_EXISTS = 3'd3,
    RC_TABLE_FULL     = 3'd4,
    RC_REF_OVERFLOW   = 3'd5
  } status_t;

  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_USED    = 2'd1;
  localparam logic [1:0] ST_PENDING = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] handle_index;
    logic [15:0] target_index;
    logic [31:0] instance_value;
    logic        owned;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [8:0]  result_index;
    logic [31:0] instance_out;
    logic        released;
    logic        released_owned;
    logic [8:0]  entries_in_use;
  } res_t;

endpackage

`default_nettype wire

[hdl/rht_mem.sv]
// ----------------------------------------------------------------------------
// Handle table entry memory
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rht_mem #(
  parameter int DEPTH = rht_pkg::ENTRIES_DEF,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/rht_ctrl.sv]
// ----------------------------------------------------------------------------
// Handle table request sequencer
// Reads an entry, decides the request and writes the entry back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rht_ctrl #(
  parameter int ENTRIES   = rht_pkg::ENTRIES_DEF,
  parameter int REF_WIDTH = rht_pkg::REF_WIDTH_DEF,
  parameter int TAG_WIDTH = rht_pkg::TAG_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rht_pkg::req_t in_req,
  output logic               res_valid,
  input  wire logic          res_ready,
  output rht_pkg::res_t      res
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int UCW   = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic [1:0]           st;
    logic [REF_WIDTH-1:0] cnt;
    logic                 own;
    logic [TAG_WIDTH-1:0] tag;
  } entry_t;

  localparam int EW = $bits(entry_t);
  localparam logic [REF_WIDTH-1:0] CNT_ONE = REF_WIDTH'(1);
  localparam logic [REF_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [16:0] ENTRIES_W = 17'(ENTRIES);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD_H, S_RD_T, S_EVAL, S_WR_T, S_SCAN, S_DONE
  } state_t;

  state_t            state;
  rht_pkg::req_t     req;
  logic [IDX_W-1:0]  h_idx;
  logic [IDX_W-1:0]  t_idx;
  logic              t_range;
  entry_t            ent_h;
  logic [IDX_W-1:0]  scan_addr;
  logic [IDX_W-1:0]  chk_addr;
  logic              chk_valid;
  logic [IDX_W-1:0]  clr_addr;
  logic [UCW-1:0]    used_count;

  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  entry_t            mem_wr_data;
  logic              mem_rd_en;
  logic [IDX_W-1:0]  mem_rd_addr;
  logic [EW-1:0]     mem_rd_raw;
  entry_t            rd_ent;

  rht_mem #(.DEPTH(ENTRIES), .WIDTH(EW), .AW(IDX_W)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_raw)
  );

  assign rd_ent = entry_t'(mem_rd_raw);

  // Range checks on the incoming request.
  logic in_h_range, in_t_range;
  assign in_h_range = (in_req.handle_index != 16'd0) &&
                      ({1'b0, in_req.handle_index} <= ENTRIES_W);
  assign in_t_range = (in_req.target_index != 16'd0) &&
                      ({1'b0, in_req.target_index} <= ENTRIES_W);

  logic            early_done;
  rht_pkg::status_t early_status;

  always_comb begin
    early_done   = 1'b0;
    early_status = rht_pkg::RC_OK;
    unique case (in_req.op)
      rht_pkg::OP_ADD: begin
        if (used_count == UCW'(ENTRIES)) begin
          early_done   = 1'b1;
          early_status = rht_pkg::RC_TABLE_FULL;
        end
      end
      rht_pkg::OP_CREATE: begin
        if (in_req.handle_index == 16'd0) begin
          early_done   = 1'b1;
          early_status = rht_pkg::RC_INVALID_HANDLE;
        end else if (!in_h_range) begin
          early_done   = 1'b1;
          early_status = rht_pkg::RC_TABLE_FULL;
        end
      end
      rht_pkg::OP_MOVE: begin
        if (!in_h_range || in_req.target_index == 16'd0) begin
          early_done   = 1'b1;
          early_status = rht_pkg::RC_INVALID_HANDLE;
        end
      end
      rht_pkg::OP_DESTROY: begin
        if (!in_h_range || used_count == '0) begin
          early_done   = 1'b1;
          early_status = rht_pkg::RC_INVALID_HANDLE;
        end
      end
      rht_pkg::OP_CHECKOUT, rht_pkg::OP_CHECKIN, rht_pkg::OP_VALIDATE: begin
        if (!in_h_range) begin
          early_done   = 1'b1;
          early_status = rht_pkg::RC_INVALID_HANDLE;
        end
      end
      default: begin
        early_done   = 1'b1;
        early_status = rht_pkg::RC_INVALID_STATE;
      end
    endcase
  end

  // Decision on the entry read back. For a move the source entry was held
  // in ent_h and the read data is the destination.
  entry_t           e;
  rht_pkg::status_t ev_status;
  logic [31:0]      ev_inst;
  logic             ev_rel, ev_rel_own, ev_wr, ev_inc, ev_dec;
  entry_t           ev_data;
  logic [UCW-1:0]   used_after;

  always_comb begin
    e          = (req.op == rht_pkg::OP_MOVE) ? ent_h : rd_ent;
    ev_status  = rht_pkg::RC_OK;
    ev_inst    = 32'd0;
    ev_rel     = 1'b0;
    ev_rel_own = 1'b0;
    ev_wr      = 1'b0;
    ev_inc     = 1'b0;
    ev_dec     = 1'b0;
    ev_data    = e;
    unique case (req.op)
      rht_pkg::OP_CREATE: begin
        if (e.st != rht_pkg::ST_EMPTY) begin
          ev_status = rht_pkg::RC_ALREADY_EXISTS;
        end else begin
          ev_wr   = 1'b1;
          ev_inc  = 1'b1;
          ev_data = '{st: rht_pkg::ST_USED, cnt: CNT_ONE, own: 1'b0,
                      tag: TAG_WIDTH'(req.instance_value)};
        end
      end
      rht_pkg::OP_MOVE: begin
        if (e.cnt != CNT_ONE) begin
          ev_status = rht_pkg::RC_INVALID_STATE;
        end else if (t_range && rd_ent.cnt != '0) begin
          ev_status = rht_pkg::RC_ALREADY_EXISTS;
        end else if (e.tag == '0) begin
          ev_status = rht_pkg::RC_INVALID_STATE;
        end else if (!t_range) begin
          ev_status = rht_pkg::RC_TABLE_FULL;
        end else begin
          ev_wr   = 1'b1;
          ev_data = '0;
        end
      end
      rht_pkg::OP_DESTROY: begin
        if (e.st == rht_pkg::ST_USED) begin
          ev_wr = 1'b1;
          if (e.cnt == '0) begin
            ev_status  = rht_pkg::RC_INVALID_STATE;
            ev_data.st = rht_pkg::ST_PENDING;
          end else if (e.cnt == CNT_ONE) begin
            ev_inst    = 32'(e.tag);
            ev_rel     = 1'b1;
            ev_rel_own = e.own;
            ev_dec     = 1'b1;
            ev_data    = '0;
          end else begin
            ev_data.st  = rht_pkg::ST_PENDING;
            ev_data.cnt = e.cnt - CNT_ONE;
          end
        end else if (e.st == rht_pkg::ST_EMPTY) begin
          ev_status = rht_pkg::RC_INVALID_HANDLE;
        end
      end
      rht_pkg::OP_CHECKOUT: begin
        if (e.st != rht_pkg::ST_USED) begin
          ev_status = rht_pkg::RC_INVALID_HANDLE;
        end else if (e.cnt == CNT_MAX) begin
          ev_status = rht_pkg::RC_REF_OVERFLOW;
        end else begin
          ev_inst     = 32'(e.tag);
          ev_wr       = 1'b1;
          ev_data.cnt = e.cnt + CNT_ONE;
        end
      end
      rht_pkg::OP_CHECKIN: begin
        if (e.cnt == '0) begin
          ev_status = rht_pkg::RC_INVALID_STATE;
        end else if (e.cnt == CNT_ONE && e.st != rht_pkg::ST_PENDING) begin
          ev_status = rht_pkg::RC_INVALID_STATE;
        end else if (e.cnt == CNT_ONE) begin
          ev_inst    = 32'(e.tag);
          ev_rel     = 1'b1;
          ev_rel_own = e.own;
          ev_dec     = 1'b1;
          ev_wr      = 1'b1;
          ev_data    = '0;
        end else begin
          ev_wr       = 1'b1;
          ev_data.cnt = e.cnt - CNT_ONE;
        end
      end
      rht_pkg::OP_VALIDATE: begin
        if (e.st != rht_pkg::ST_USED) begin
          ev_status = rht_pkg::RC_INVALID_HANDLE;
        end
      end
      default: begin
        ev_status = rht_pkg::RC_INVALID_STATE;
      end
    endcase
    if (ev_inc) begin
      used_after = used_count + UCW'(1);
    end else if (ev_dec && used_count != '0) begin
      used_after = used_count - UCW'(1);
    end else begin
      used_after = used_count;
    end
  end

  logic scan_hit;
  assign scan_hit = (state == S_SCAN) && chk_valid && (rd_ent.st == rht_pkg::ST_EMPTY);

  // Memory port steering.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = h_idx;
    mem_wr_data = ev_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = h_idx;
    unique case (state)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr;
        mem_wr_data = '0;
      end
      S_RD_H: begin
        mem_rd_en = 1'b1;
      end
      S_RD_T: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = t_idx;
      end
      S_EVAL: begin
        mem_wr_en = ev_wr;
      end
      S_WR_T: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = t_idx;
        mem_wr_data = '{st: rht_pkg::ST_USED, cnt: CNT_ONE, own: ent_h.own, tag: ent_h.tag};
      end
      S_SCAN: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = scan_addr;
        mem_wr_en   = scan_hit;
        mem_wr_addr = chk_addr;
        mem_wr_data = '{st: rht_pkg::ST_USED, cnt: CNT_ONE, own: req.owned,
                        tag: TAG_WIDTH'(req.instance_value)};
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      used_count <= '0;
      chk_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == IDX_W'(ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req       <= in_req;
            h_idx     <= IDX_W'(in_req.handle_index - 16'd1);
            t_idx     <= IDX_W'(in_req.target_index - 16'd1);
            t_range   <= in_t_range;
            scan_addr <= '0;
            chk_valid <= 1'b0;
            res.status         <= early_status;
            res.result_index   <= (in_req.op == rht_pkg::OP_ADD) ? 9'd0
                                                                 : in_req.handle_index[8:0];
            res.instance_out   <= 32'd0;
            res.released       <= 1'b0;
            res.released_owned <= 1'b0;
            res.entries_in_use <= 9'(used_count);
            if (early_done) begin
              state <= S_DONE;
            end else if (in_req.op == rht_pkg::OP_ADD) begin
              state <= S_SCAN;
            end else begin
              state <= S_RD_H;
            end
          end
        end
        S_RD_H: begin
          state <= (req.op == rht_pkg::OP_MOVE) ? S_RD_T : S_EVAL;
        end
        S_RD_T: begin
          ent_h <= rd_ent;
          state <= S_EVAL;
        end
        S_EVAL: begin
          used_count         <= used_after;
          res.status         <= ev_status;
          res.instance_out   <= ev_inst;
          res.released       <= ev_rel;
          res.released_owned <= ev_rel_own;
          res.entries_in_use <= 9'(used_after);
          if (req.op == rht_pkg::OP_MOVE && ev_wr) begin
            state <= S_WR_T;
          end else begin
            state <= S_DONE;
          end
        end
        S_WR_T: begin
          state <= S_DONE;
        end
        S_SCAN: begin
          scan_addr <= scan_addr + IDX_W'(1);
          chk_addr  <= scan_addr;
          chk_valid <= 1'b1;
          if (scan_hit) begin
            used_count         <= used_count + UCW'(1);
            res.status         <= rht_pkg::RC_OK;
            res.result_index   <= 9'({1'b0, chk_addr} + (IDX_W + 1)'(1));
            res.entries_in_use <= 9'(used_count + UCW'(1));
            state              <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= UCW'(ENTRIES))
    else $error("used count above table size");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !mem_wr_en)
    else $error("entry write outside a request");

  a_release_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.released) |-> (res.status == rht_pkg::RC_OK))
    else $error("release with failing status");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("request taken during clearing pass");

endmodule

`default_nettype wire

[hdl/refcounted_handle_table.sv]
// ----------------------------------------------------------------------------
// Reference-counted handle table
// Serves add, create, move, destroy, checkout, checkin and validate requests
// on a table of reference-counted entries held in one RAM.
// ----------------------------------------------------------------------------
//  Channel | Dir | Contents
//  s_*     | in  | request: tuser = req_type, tdata = indices, tag, owned
//  m_*     | out | result:  tuser = status, tdata = index, tag, flags, count
//
//  A request other than add goes from its transfer through the read, decide
//  and write-back of one entry in the single RAM port pair; a move also reads
//  and writes its destination entry, and one that its fields alone decide
//  skips the RAM. Add scans the RAM one entry per cycle for the lowest
//  empty slot. After reset a clearing pass over all ENTRIES entries runs
//  before the first request is taken. One request is in work at a time; the
//  output register lets the next request in while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module refcounted_handle_table #(
  parameter int ENTRIES   = rht_pkg::ENTRIES_DEF,
  parameter int REF_WIDTH = rht_pkg::REF_WIDTH_DEF,
  parameter int TAG_WIDTH = rht_pkg::TAG_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [15:0] handle_index, [31:16] target_index, [63:32] instance_value,
  // [64] owned, [71:65] zero
  input  wire logic [rht_pkg::S_TDATA_W-1:0] s_tdata,
  // [2:0] req_type
  input  wire logic [2:0]                    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [8:0] result_index, [40:9] instance_out, [41] released,
  // [42] released_owned, [51:43] entries_in_use, [55:52] zero
  output logic      [rht_pkg::M_TDATA_W-1:0] m_tdata,
  // [2:0] status
  output logic      [2:0]                    m_tuser
);

  rht_pkg::req_t req;
  rht_pkg::res_t res;
  rht_pkg::res_t out_res;
  logic          res_valid;
  logic          res_ready;

  assign req.op             = s_tuser;
  assign req.handle_index   = s_tdata[15:0];
  assign req.target_index   = s_tdata[31:16];
  assign req.instance_value = s_tdata[63:32];
  assign req.owned          = s_tdata[64];

  rht_ctrl #(.ENTRIES(ENTRIES), .REF_WIDTH(REF_WIDTH), .TAG_WIDTH(TAG_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.status;
  assign m_tdata = {4'd0, out_res.entries_in_use, out_res.released_owned,
                    out_res.released, out_res.instance_out, out_res.result_index};

endmodule

`default_nettype wire
